// ===== hdl/gamepad_input_qualifier_top_macros.svh =====
// Assertion macros shared by the gamepad input qualifier RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef GAMEPAD_INPUT_QUALIFIER_TOP_MACROS_SVH
`define GAMEPAD_INPUT_QUALIFIER_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define GPIQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define GPIQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gpiq_pkg.sv =====
// Shared types, codes and constants for the gamepad input qualifier.
// Used by every RTL module of the block; depends on nothing else.
package gpiq_pkg;

  // Number of controller ports that keep state.
  localparam int NUM_PORTS  = 4;
  localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // Sample status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_CTRL = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] REG_REPEAT_DELAY      = 2'd0;
  localparam logic [1:0] REG_STICK_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_CSTICK_THRESHOLD  = 2'd2;
  localparam logic [1:0] REG_TRIGGER_THRESHOLD = 2'd3;

  // Configuration reset values.
  localparam logic [6:0] RST_REPEAT_DELAY      = 7'd5;
  localparam logic [6:0] RST_STICK_THRESHOLD   = 7'd35;
  localparam logic [6:0] RST_CSTICK_THRESHOLD  = 7'd40;
  localparam logic [7:0] RST_TRIGGER_THRESHOLD = 8'd10;

  // Direction pulse codes (two bits, two's complement).
  localparam logic [1:0] PULSE_NONE = 2'b00;
  localparam logic [1:0] PULSE_POS  = 2'b01;
  localparam logic [1:0] PULSE_NEG  = 2'b11;

  typedef struct packed {
    logic [6:0] repeat_delay;
    logic [6:0] stick_threshold;
    logic [6:0] cstick_threshold;
    logic [7:0] trigger_threshold;
  } cfg_t;

  // One input transaction; last field in the lowest bits.
  typedef struct packed {
    logic [7:0]  trigger_right;
    logic [7:0]  trigger_left;
    logic [7:0]  cstick_y;
    logic [7:0]  cstick_x;
    logic [7:0]  stick_y;
    logic [7:0]  stick_x;
    logic [15:0] buttons;
    logic        read_ready;
    logic [1:0]  status;
    logic [1:0]  port;
  } sample_t;

  // One result transaction; last field in the lowest bits.
  typedef struct packed {
    logic [1:0]  dir_pulse_y;
    logic [1:0]  dir_pulse_x;
    logic [1:0]  triggers_released;
    logic [1:0]  triggers_pressed;
    logic [1:0]  trigger_bits;
    logic [19:0] buttons_released;
    logic [19:0] buttons_pressed;
    logic [19:0] buttons_held;
    logic        controller_missing;
    logic [1:0]  port_out;
  } result_t;

  // State of one main stick axis.
  typedef struct packed {
    logic [7:0] last;
    logic [7:0] count;
    logic [1:0] pulse;
  } axis_state_t;

  // Everything kept for one controller port.
  typedef struct packed {
    axis_state_t axis_x;
    axis_state_t axis_y;
    logic [19:0] prev_buttons;
    logic [19:0] pressed_bits;
    logic [19:0] released_bits;
    logic [1:0]  prev_trigger_bits;
    logic [1:0]  trig_pressed_bits;
    logic [1:0]  trig_released_bits;
  } port_state_t;

  localparam int SAMPLE_W    = $bits(sample_t);
  localparam int RESULT_W    = $bits(result_t);
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== hdl/gamepad_input_qualifier_top.sv =====
// Gamepad input qualifier: a sample passes an input register, then a result register.
// Throughput one transaction per cycle unless stalled, on the same port or any other:
// the per-port state is read, updated and written between the input and result registers.
// Reset (rst_n low at a clock edge) empties both registers, clears every port's state
// and returns the configuration registers to their defaults.
// Depends on gpiq_pkg, gpiq_cfg_regs, gpiq_qualify and the assertion macro header.
`include "gamepad_input_qualifier_top_macros.svh"

module gamepad_input_qualifier_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // port, status, read_ready, buttons, stick_x, stick_y, cstick_x, cstick_y,
  // trigger_left, trigger_right; zero padding on top.
  input  logic [gpiq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // port_out, controller_missing, buttons_held, buttons_pressed, buttons_released,
  // trigger_bits, triggers_pressed, triggers_released, dir_pulse_x, dir_pulse_y;
  // zero padding on top.
  output logic [gpiq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [7:0]                          cfg_wdata
);

  gpiq_pkg::cfg_t                     cfg;
  logic                               a_valid_r;
  gpiq_pkg::sample_t                  a_smp_r;
  logic                               adv;
  logic [gpiq_pkg::PORT_IDX_W-1:0]    a_idx;
  logic                               a_in_range;
  logic                               a_missing;
  logic                               a_good;
  gpiq_pkg::port_state_t              state_r [gpiq_pkg::NUM_PORTS];
  gpiq_pkg::port_state_t              cur_st;
  gpiq_pkg::port_state_t              good_st;
  gpiq_pkg::port_state_t              rep_st;
  gpiq_pkg::result_t                  res_nxt;
  gpiq_pkg::result_t                  res_r;
  logic                               out_valid_r;

  gpiq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Handshake: the input register moves on whenever the result register is free.
  assign adv       = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_smp_r <= gpiq_pkg::sample_t'(in_tdata[gpiq_pkg::SAMPLE_W-1:0]);
    end
  end

  // Classify the registered sample and read its port's state.
  always_comb begin
    a_idx      = gpiq_pkg::PORT_IDX_W'(a_smp_r.port);
    a_in_range = 32'(a_smp_r.port) < gpiq_pkg::NUM_PORTS;
    a_missing  = a_smp_r.status == gpiq_pkg::STATUS_NO_CTRL;
    a_good     = (a_smp_r.status == gpiq_pkg::STATUS_OK) && a_smp_r.read_ready;
    cur_st     = state_r[a_idx];
  end

  gpiq_qualify u_qualify (
    .cfg (cfg),
    .smp (a_smp_r),
    .cur (cur_st),
    .nxt (good_st)
  );

  // Build the result from the state as it stands after this sample.
  always_comb begin
    rep_st  = a_good ? good_st : cur_st;
    res_nxt = '0;
    res_nxt.port_out = a_smp_r.port;
    if (!a_in_range || a_missing) begin
      res_nxt.controller_missing = 1'b1;
    end else begin
      res_nxt.buttons_held      = rep_st.prev_buttons;
      res_nxt.buttons_pressed   = rep_st.pressed_bits;
      res_nxt.buttons_released  = rep_st.released_bits;
      res_nxt.trigger_bits      = rep_st.prev_trigger_bits;
      res_nxt.triggers_pressed  = rep_st.trig_pressed_bits;
      res_nxt.triggers_released = rep_st.trig_released_bits;
      res_nxt.dir_pulse_x       = rep_st.axis_x.pulse;
      res_nxt.dir_pulse_y       = rep_st.axis_y.pulse;
    end
  end

  // Per-port state: cleared on no controller, updated on a good sample, else kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < gpiq_pkg::NUM_PORTS; p++) begin
        state_r[p] <= '0;
      end
    end else if (adv && a_in_range) begin
      if (a_missing) begin
        state_r[a_idx] <= '0;
      end else if (a_good) begin
        state_r[a_idx] <= good_st;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(gpiq_pkg::OUT_TDATA_W - gpiq_pkg::RESULT_W){1'b0}}, res_r};

  // A stalled input side always means a sample is waiting in the input register.
  `GPIQ_ASSERT_IMPL(a_stall_has_item, !in_tready, a_valid_r, "input stalled with empty stage")

  // A no-controller sample yields a result flagged as missing.
  `GPIQ_ASSERT_NEXT(a_missing_flagged, adv && a_missing, out_valid_r && res_r.controller_missing, "missing flag lost")

  // A no-controller sample leaves that port fully cleared.
  `GPIQ_ASSERT_NEXT(a_missing_clears, adv && a_in_range && a_missing, state_r[$past(a_idx)] == '0, "port state not cleared")

  // A held sample leaves that port's state untouched.
  `GPIQ_ASSERT_NEXT(a_hold_keeps, adv && a_in_range && !a_missing && !a_good, state_r[$past(a_idx)] == $past(cur_st), "held sample changed state")

endmodule

// ===== hdl/gpiq_cfg_regs.sv =====
// Configuration registers of the gamepad input qualifier.
// Depends on gpiq_pkg for the register indexes and reset values.
module gpiq_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [7:0]           cfg_wdata,
  output gpiq_pkg::cfg_t       cfg
);

  gpiq_pkg::cfg_t cfg_r;
  gpiq_pkg::cfg_t cfg_nxt;

  // Decode the write onto the addressed register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        gpiq_pkg::REG_REPEAT_DELAY:      cfg_nxt.repeat_delay      = cfg_wdata[6:0];
        gpiq_pkg::REG_STICK_THRESHOLD:   cfg_nxt.stick_threshold   = cfg_wdata[6:0];
        gpiq_pkg::REG_CSTICK_THRESHOLD:  cfg_nxt.cstick_threshold  = cfg_wdata[6:0];
        gpiq_pkg::REG_TRIGGER_THRESHOLD: cfg_nxt.trigger_threshold = cfg_wdata;
        default:                         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_delay      <= gpiq_pkg::RST_REPEAT_DELAY;
      cfg_r.stick_threshold   <= gpiq_pkg::RST_STICK_THRESHOLD;
      cfg_r.cstick_threshold  <= gpiq_pkg::RST_CSTICK_THRESHOLD;
      cfg_r.trigger_threshold <= gpiq_pkg::RST_TRIGGER_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/gpiq_stick_axis.sv =====
// Direction pulse, hold counter and re-arm logic for one main stick axis.
// Depends on gpiq_pkg for the axis state type and pulse codes.
module gpiq_stick_axis (
  input  logic [6:0]                threshold,
  input  logic [6:0]                repeat_delay,
  input  logic [7:0]                pos,
  input  gpiq_pkg::axis_state_t     cur,
  output gpiq_pkg::axis_state_t     nxt
);

  logic signed [8:0] pos_s;
  logic signed [8:0] last_s;
  logic signed [8:0] thr_s;
  logic              neg_now;
  logic              pos_now;
  logic              neg_last;
  logic              pos_last;
  logic              fire_neg;
  logic              fire_pos;
  logic [7:0]        count_base;
  logic [7:0]        count_inc;
  logic              rearm;

  // Compare the sample and the remembered position against the threshold.
  always_comb begin
    pos_s    = $signed({pos[7], pos});
    last_s   = $signed({cur.last[7], cur.last});
    thr_s    = $signed({2'b00, threshold});
    neg_now  = pos_s < -thr_s;
    pos_now  = pos_s > thr_s;
    neg_last = last_s < -thr_s;
    pos_last = last_s > thr_s;
    fire_neg = neg_now && !neg_last;
    fire_pos = pos_now && !pos_last;
  end

  // A fresh crossing fires a pulse and restarts the hold count; a long hold re-arms.
  always_comb begin
    count_base = (fire_neg || fire_pos) ? 8'd0 : cur.count;
    count_inc  = (neg_now || pos_now) ? count_base + 8'd1 : 8'd0;
    rearm      = count_inc > {1'b0, repeat_delay};
    nxt.last   = rearm ? 8'd0 : pos;
    nxt.count  = rearm ? 8'd0 : count_inc;
    if (fire_pos) begin
      nxt.pulse = gpiq_pkg::PULSE_POS;
    end else if (fire_neg) begin
      nxt.pulse = gpiq_pkg::PULSE_NEG;
    end else begin
      nxt.pulse = gpiq_pkg::PULSE_NONE;
    end
  end

endmodule

// ===== hdl/gpiq_qualify.sv =====
// Next port state for a good sample: C-stick folding, button and trigger edges,
// and both stick axes. Depends on gpiq_pkg and gpiq_stick_axis.
module gpiq_qualify (
  input  gpiq_pkg::cfg_t        cfg,
  input  gpiq_pkg::sample_t     smp,
  input  gpiq_pkg::port_state_t cur,
  output gpiq_pkg::port_state_t nxt
);

  logic signed [8:0] cx_s;
  logic signed [8:0] cy_s;
  logic signed [8:0] ct_s;
  logic [19:0]       held;
  logic [19:0]       btn_diff;
  logic [1:0]        trig;
  logic [1:0]        trig_diff;

  // Threshold the C-stick into four direction bits above the buttons.
  always_comb begin
    cx_s = $signed({smp.cstick_x[7], smp.cstick_x});
    cy_s = $signed({smp.cstick_y[7], smp.cstick_y});
    ct_s = $signed({2'b00, cfg.cstick_threshold});
    held = {cx_s > ct_s, cx_s < -ct_s, cy_s < -ct_s, cy_s > ct_s, smp.buttons};
  end

  // Digital trigger bits: right in bit 0, left in bit 1.
  assign trig = {smp.trigger_left > cfg.trigger_threshold,
                 smp.trigger_right > cfg.trigger_threshold};

  // Pressed and released edges against the last good sample.
  always_comb begin
    btn_diff               = held ^ cur.prev_buttons;
    trig_diff              = trig ^ cur.prev_trigger_bits;
    nxt.prev_buttons       = held;
    nxt.pressed_bits       = held & btn_diff;
    nxt.released_bits      = cur.prev_buttons & btn_diff;
    nxt.prev_trigger_bits  = trig;
    nxt.trig_pressed_bits  = trig & trig_diff;
    nxt.trig_released_bits = cur.prev_trigger_bits & trig_diff;
  end

  gpiq_stick_axis u_axis_x (
    .threshold    (cfg.stick_threshold),
    .repeat_delay (cfg.repeat_delay),
    .pos          (smp.stick_x),
    .cur          (cur.axis_x),
    .nxt          (nxt.axis_x)
  );

  gpiq_stick_axis u_axis_y (
    .threshold    (cfg.stick_threshold),
    .repeat_delay (cfg.repeat_delay),
    .pos          (smp.stick_y),
    .cur          (cur.axis_y),
    .nxt          (nxt.axis_y)
  );

endmodule
